### rtl/uuencode_line_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// uuencode line encoder - assertion macros
// Shared concurrent assertion forms for the encoder's checker.
// ----------------------------------------------------------------------------
`ifndef UUENCODE_LINE_ENCODER_UNIT_MACROS_SVH
`define UUENCODE_LINE_ENCODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UULE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UULE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uule_pkg.sv
// ----------------------------------------------------------------------------
// uuencode line encoder - package
// Shared types, character constants and the 6-bit symbol mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package uule_pkg;

  // Width of the line byte counter; holds a full line of up to 63 bytes.
  localparam int CNT_W = 6;

  // Bytes per encoded group.
  localparam int GRP_BYTES = 3;

  // Fetch slot value that means the group prefetch is complete.
  localparam logic [1:0] FETCH_DONE = 2'd3;

  // Output characters.
  localparam logic [6:0] CHAR_NL   = 7'd10;
  localparam logic [6:0] CHAR_ZERO = 7'd96;
  localparam logic [6:0] CHAR_BASE = 7'd32;

  // Which character the datapath places in the output register.
  typedef enum logic [2:0] {
    SEL_LEN  = 3'd0,
    SEL_C0   = 3'd1,
    SEL_C1   = 3'd2,
    SEL_C2   = 3'd3,
    SEL_C3   = 3'd4,
    SEL_NL   = 3'd5,
    SEL_ZERO = 3'd6
  } sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input request is taken this cycle
    logic load;    // load the output register
    sel_t sel;     // character to load
    logic last;    // last character caused by the current request
    logic copy;    // move the prefetched group into the working group
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_go;     // the offered request completes or flushes a line
    logic fetch_done;  // next group is fully prefetched
    logic out_free;    // output register can take a character
    logic last_group;  // working group is the last group of the line
  } dp_sts_t;

  // Map a 6-bit value to its character; zero is written as backquote.
  function automatic logic [6:0] enc6(input logic [5:0] v);
    logic [6:0] ch;
    if (v == 6'd0) begin
      ch = CHAR_ZERO;
    end else begin
      ch = CHAR_BASE + {1'b0, v};
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/uule_datapath.sv
// ----------------------------------------------------------------------------
// uuencode line encoder - datapath
// Line memory, byte counter, group prefetch, character mapping and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uule_datapath #(
  parameter int LINE_BYTES = 45
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data,
  input  logic              in_has,
  input  logic              in_end,
  input  uule_pkg::dp_cmd_t cmd,
  output uule_pkg::dp_sts_t sts,
  output logic [6:0]        out_char,
  output logic              out_last,
  output logic              out_valid,
  input  logic              out_ready
);
  import uule_pkg::*;

  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam logic [CNT_W-1:0] LINE_LEN = CNT_W'(LINE_BYTES);
  localparam logic [CNT_W-1:0] GRP_STEP = CNT_W'(GRP_BYTES);

  logic [7:0]       line_mem [0:LINE_BYTES-1];
  logic [CNT_W-1:0] line_count_r;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] grp_base_r;
  logic [CNT_W-1:0] next_base_r;
  logic [CNT_W:0]   grp_end;
  logic [1:0]       fslot_r;
  logic             fetch_en;
  logic             rd_hit;
  logic             line_go;
  logic             line_start;
  logic [7:0]       nxt_a_r, nxt_b_r, nxt_c_r;
  logic [7:0]       grp_a_r, grp_b_r, grp_c_r;
  logic [6:0]       char_sel;
  logic [6:0]       out_char_r;
  logic             out_last_r;
  logic             out_valid_r;

  // Byte count after the offered request and whether a line must go out.
  assign cnt_inc    = line_count_r + CNT_W'(in_has);
  assign line_go    = (in_has && (cnt_inc == LINE_LEN)) || (in_end && (cnt_inc != '0));
  assign line_start = cmd.accept && line_go;

  // Line byte counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
    end else if (cmd.accept) begin
      line_count_r <= line_go ? '0 : cnt_inc;
    end
  end

  // Line memory write; the counter is always below the line length here.
  always_ff @(posedge clk) begin
    if (cmd.accept && in_has) begin
      line_mem[line_count_r[AW-1:0]] <= in_data;
    end
  end

  // Length of the line being emitted.
  always_ff @(posedge clk) begin
    if (line_start) begin
      len_r <= cnt_inc;
    end
  end

  // Group prefetch: three reads, one per cycle, bytes past the line read as zero.
  assign fetch_en = (fslot_r != FETCH_DONE);
  assign rd_hit   = (rd_ptr_r < len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fslot_r <= FETCH_DONE;
    end else if (line_start || cmd.copy) begin
      fslot_r <= 2'd0;
    end else if (fetch_en) begin
      fslot_r <= fslot_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (line_start) begin
      rd_ptr_r <= '0;
    end else if (fetch_en) begin
      rd_ptr_r <= rd_ptr_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_en) begin
      nxt_a_r <= nxt_b_r;
      nxt_b_r <= nxt_c_r;
      if (rd_hit) begin
        nxt_c_r <= line_mem[rd_ptr_r[AW-1:0]];
      end else begin
        nxt_c_r <= 8'h00;
      end
    end
  end

  // Working group and its position within the line.
  always_ff @(posedge clk) begin
    if (line_start) begin
      next_base_r <= '0;
    end else if (cmd.copy) begin
      grp_a_r     <= nxt_a_r;
      grp_b_r     <= nxt_b_r;
      grp_c_r     <= nxt_c_r;
      grp_base_r  <= next_base_r;
      next_base_r <= next_base_r + GRP_STEP;
    end
  end

  assign grp_end = {1'b0, grp_base_r} + {1'b0, GRP_STEP};

  // Character selection.
  always_comb begin
    case (cmd.sel)
      SEL_LEN:  char_sel = enc6(len_r);
      SEL_C0:   char_sel = enc6(grp_a_r[7:2]);
      SEL_C1:   char_sel = enc6({grp_a_r[1:0], grp_b_r[7:4]});
      SEL_C2:   char_sel = enc6({grp_b_r[3:0], grp_c_r[7:6]});
      SEL_C3:   char_sel = enc6(grp_c_r[5:0]);
      SEL_NL:   char_sel = CHAR_NL;
      SEL_ZERO: char_sel = CHAR_ZERO;
      default:  char_sel = CHAR_NL;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_char_r <= char_sel;
      out_last_r <= cmd.last;
    end
  end

  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_valid = out_valid_r;

  // Status toward the controller.
  assign sts.line_go    = line_go;
  assign sts.fetch_done = !fetch_en;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last_group = (grp_end >= {1'b0, len_r});

endmodule

`default_nettype wire

### rtl/uule_ctrl.sv
// ----------------------------------------------------------------------------
// uuencode line encoder - controller
// Sequences the length character, the group characters, the newline and the
// terminating line.
// ----------------------------------------------------------------------------
`default_nettype none

module uule_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  uule_pkg::dp_sts_t sts,
  output uule_pkg::dp_cmd_t cmd
);
  import uule_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_FILL    = 6'b000010,
    S_BODY    = 6'b000100,
    S_NL      = 6'b001000,
    S_TERM_Q  = 6'b010000,
    S_TERM_NL = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       fin_r, fin_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 2'd0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    fin_nxt    = fin_r;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    cmd.sel    = SEL_NL;
    cmd.last   = 1'b0;
    cmd.copy   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          fin_nxt    = in_last;
          if (sts.line_go) begin
            state_nxt = S_FILL;
          end else if (in_last) begin
            state_nxt = S_TERM_Q;
          end
        end
      end
      S_FILL: begin
        // Length character goes out once the first group is in.
        if (sts.fetch_done && sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_LEN;
          cmd.copy  = 1'b1;
          ph_nxt    = 2'd0;
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (sts.out_free) begin
          case (ph_r)
            2'd0: begin
              cmd.load = 1'b1;
              cmd.sel  = SEL_C0;
              ph_nxt   = 2'd1;
            end
            2'd1: begin
              cmd.load = 1'b1;
              cmd.sel  = SEL_C1;
              ph_nxt   = 2'd2;
            end
            2'd2: begin
              cmd.load = 1'b1;
              cmd.sel  = SEL_C2;
              ph_nxt   = 2'd3;
            end
            default: begin
              // Fourth character closes the group; advance to the next one, or to the newline after the last group.
              if (sts.last_group) begin
                cmd.load  = 1'b1;
                cmd.sel   = SEL_C3;
                ph_nxt    = 2'd0;
                state_nxt = S_NL;
              end else if (sts.fetch_done) begin
                cmd.load = 1'b1;
                cmd.sel  = SEL_C3;
                cmd.copy = 1'b1;
                ph_nxt   = 2'd0;
              end
            end
          endcase
        end
      end
      S_NL: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_NL;
          cmd.last  = !fin_r;
          state_nxt = fin_r ? S_TERM_Q : S_IDLE;
        end
      end
      S_TERM_Q: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_ZERO;
          state_nxt = S_TERM_NL;
        end
      end
      S_TERM_NL: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_NL;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/uuencode_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// uuencode line encoder - top level
// Collects input bytes into lines and streams out uuencoded text lines.
// ----------------------------------------------------------------------------
// Input channel: one request per byte (in_tuser = 1 says in_tdata holds a byte);
// in_tlast marks end of input, flushing a partial line and adding the
// terminating line (backquote, newline). A request with no byte and no end
// produces nothing. Output channel: one request per character, out_tlast on
// the final character caused by an input request.
// Bytes that do not complete a line are taken while in_tready stays high. A
// request that completes or flushes a line of n bytes gives its first
// character once the first group is fetched from the single read port of the
// line memory, then one character per cycle while the receiver takes them:
// 1 + 4*ceil(n/3) + 1 characters, plus 2 for the terminator. in_tready is low
// while a line or terminator is being sent. When the receiver stalls, output
// holds and the sequence pauses. Reset empties the line and drops any pending
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module uuencode_line_encoder_unit #(
  parameter int LINE_BYTES = 45
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] has_byte
  input  logic       in_tlast,   // end_of_input
  // Output channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // last_of_run
);
  import uule_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [6:0] out_char;

  // Controller.
  uule_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  uule_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .in_has    (in_tuser),
    .in_end    (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

### rtl/uule_checker.sv
// ----------------------------------------------------------------------------
// uuencode line encoder - port checker
// Watches the top level's ports for output character and sequencing rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uuencode_line_encoder_unit_macros.svh"

module uule_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled character stays offered and unchanged.
  `UULE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")

  // Every character is a newline or a printable symbol from space to backquote.
  `UULE_ASSERT_NOW(a_char_range, clk, rst_n, out_tvalid, (out_tdata == 8'd10) || ((out_tdata >= 8'd32) && (out_tdata <= 8'd96)), "output character out of range")

  // The final character of a run always ends a line.
  `UULE_ASSERT_NOW(a_last_is_nl, clk, rst_n, out_tvalid && out_tlast, out_tdata == 8'd10, "run does not end with newline")

  // End of input always produces output, so the block goes busy.
  `UULE_ASSERT_NEXT(a_end_busy, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "end of input not followed by output")

endmodule

bind uuencode_line_encoder_unit uule_checker u_uule_checker (.*);

`default_nettype wire
